// ===== hdl/tqs_pkg.sv =====
package tqs_pkg;

	localparam int unsigned TQS_QUEUE_DEPTH = 16;
	localparam int unsigned CFG_INDEX_W     = 4;

	localparam logic [1:0] KIND_PUSH  = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_CHIRP = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_TONE_AMPLITUDE = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STARTUP_GAP    = 4'd1;

	localparam logic [15:0] AMPLITUDE_RESET = 16'd2621;
	localparam logic [15:0] GAP_RESET       = 16'd30;

	localparam logic [15:0] CHIRP_LOW_FREQ  = 16'd880;
	localparam logic [15:0] CHIRP_LOW_DUR   = 16'd120;
	localparam logic [15:0] CHIRP_HIGH_FREQ = 16'd1320;
	localparam logic [15:0] CHIRP_HIGH_DUR  = 16'd160;

	localparam logic [1:0] CHIRP_FIRST = 2'd0;
	localparam logic [1:0] CHIRP_GAP   = 2'd1;
	localparam logic [1:0] CHIRP_LAST  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] note_freq;
		logic [15:0] note_duration;
		logic [16:0] elapsed_ms;
	} tone_cmd_t;

	typedef struct packed {
		logic [15:0] tone_freq;
		logic [15:0] tone_amplitude;
	} tone_out_t;

	typedef struct packed {
		logic [15:0] freq;
		logic [15:0] duration;
	} note_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHIRP,
		ST_READ
	} tqs_state_t;

	function automatic note_t chirp_note(input logic [1:0] step, input logic [15:0] gap);
		note_t n;
		case (step)
			CHIRP_FIRST: begin
				n.freq     = CHIRP_LOW_FREQ;
				n.duration = CHIRP_LOW_DUR;
			end
			CHIRP_GAP: begin
				n.freq     = 16'd0;
				n.duration = gap;
			end
			default: begin
				n.freq     = CHIRP_HIGH_FREQ;
				n.duration = CHIRP_HIGH_DUR;
			end
		endcase
		return n;
	endfunction

endpackage

// ===== hdl/tqs_ram.sv =====
module tqs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/tone_queue_sequencer.sv =====
// Tone queue sequencer: a ring of notes (frequency, duration in ms) that
// a tick stream plays out as tone commands.
// Channels:
//   cmd   (cmd_valid/cmd_ready): push a note, enqueue the startup chirp,
//         or report elapsed milliseconds with a tick.
//   tone  (tone_valid/tone_ready): tone commands (frequency, amplitude),
//         produced only by ticks that finish the current note.
//   cfg   (cfg_valid/cfg_ready): register writes, always ready; index 0 is
//         the amplitude, index 1 the startup gap, other indexes are ignored.
// A push or a tick that stays within the current note leaves the
// sequencer ready for the next command. A tick that dequeues a note goes
// to ST_READ; its result passes the registered note RAM read and then
// the tone register. A tick that ends playback on an empty ring shows its
// silence command the next cycle. A startup chirp holds cmd_ready low in
// ST_CHIRP while its three notes go through the single RAM write port.
// Reset empties the ring, clears the time left, loads the register reset
// values and leaves the tone silent. While a result waits on a stalled
// receiver, cmd_ready stays low; the result is held until taken.
module tone_queue_sequencer #(
	parameter int unsigned QUEUE_DEPTH = tqs_pkg::TQS_QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  tqs_pkg::tone_cmd_t                  cmd,
	output logic                                tone_valid,
	input  logic                                tone_ready,
	output tqs_pkg::tone_out_t                  tone,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tqs_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [15:0]                         cfg_data
);

	import tqs_pkg::*;

	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

	tqs_state_t state_q, state_d;
	logic [IDX_W-1:0] wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
	logic [15:0] time_left_q, time_left_d;
	logic [1:0] chirp_step_q, chirp_step_d;
	logic [15:0] amplitude_q, gap_q;
	logic tone_valid_q, tone_valid_d;
	tone_out_t tone_q, tone_d;
	logic tone_load;

	logic cmd_fire;
	logic ring_empty, ring_full;
	logic [IDX_W-1:0] wr_next, rd_next;
	logic tick_past;

	logic ram_we, ram_re;
	note_t ram_wdata, ram_rdata, chirp_entry;

	tqs_ram #(
		.WIDTH ($bits(note_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_note_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	assign wr_next    = (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + 1'b1;
	assign rd_next    = (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + 1'b1;
	assign ring_empty = (wr_idx_q == rd_idx_q);
	assign ring_full  = (wr_next == rd_idx_q);
	assign tick_past  = cmd.elapsed_ms > {1'b0, time_left_q};

	assign cmd_ready   = (state_q == ST_IDLE) && (!tone_valid_q || tone_ready);
	assign cmd_fire    = cmd_valid && cmd_ready;
	assign cfg_ready   = 1'b1;
	assign chirp_entry = chirp_note(chirp_step_q, gap_q);

	always_comb begin
		state_d      = state_q;
		wr_idx_d     = wr_idx_q;
		rd_idx_d     = rd_idx_q;
		time_left_d  = time_left_q;
		chirp_step_d = chirp_step_q;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		ram_wdata    = '{freq: cmd.note_freq, duration: cmd.note_duration};
		tone_load    = 1'b0;
		tone_d       = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					case (cmd.kind)
						KIND_PUSH: begin
							if (!ring_full) begin
								ram_we   = 1'b1;
								wr_idx_d = wr_next;
							end
						end
						KIND_CHIRP: begin
							state_d      = ST_CHIRP;
							chirp_step_d = CHIRP_FIRST;
						end
						KIND_TICK: begin
							if (!tick_past) begin
								time_left_d = time_left_q - cmd.elapsed_ms[15:0];
							end else if (!ring_empty) begin
								ram_re  = 1'b1;
								state_d = ST_READ;
							end else if (time_left_q != 16'd0) begin
								time_left_d = 16'd0;
								tone_load   = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_CHIRP: begin
				ram_wdata = chirp_entry;
				if (!ring_full) begin
					ram_we   = 1'b1;
					wr_idx_d = wr_next;
				end
				chirp_step_d = chirp_step_q + 2'd1;
				if (chirp_step_q == CHIRP_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				rd_idx_d             = rd_next;
				time_left_d          = ram_rdata.duration;
				tone_load            = 1'b1;
				tone_d.tone_freq     = ram_rdata.freq;
				tone_d.tone_amplitude = (ram_rdata.freq == 16'd0) ? 16'd0 : amplitude_q;
				state_d              = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		tone_valid_d = tone_load || (tone_valid_q && !tone_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			time_left_q  <= '0;
			chirp_step_q <= CHIRP_FIRST;
			tone_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			wr_idx_q     <= wr_idx_d;
			rd_idx_q     <= rd_idx_d;
			time_left_q  <= time_left_d;
			chirp_step_q <= chirp_step_d;
			tone_valid_q <= tone_valid_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= AMPLITUDE_RESET;
			gap_q       <= GAP_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_TONE_AMPLITUDE) begin
				amplitude_q <= cfg_data;
			end
			if (cfg_index == REG_STARTUP_GAP) begin
				gap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tone_load) begin
			tone_q <= tone_d;
		end
	end

	assign tone_valid = tone_valid_q;
	assign tone       = tone_q;

endmodule

// ===== hdl/tqs_checker.sv =====
module tqs_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  logic                            cmd_ready,
	input  tqs_pkg::tone_cmd_t              cmd,
	input  logic                            tone_valid,
	input  logic                            tone_ready,
	input  tqs_pkg::tone_out_t              tone,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready
);

	import tqs_pkg::*;

	a_tone_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tone_valid && !tone_ready |=> tone_valid && $stable(tone))
		else $error("tone changed while stalled");

	a_stall_blocks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		tone_valid && !tone_ready |-> !cmd_ready)
		else $error("command taken while tone stalled");

	a_silent_zero_amp: assert property (@(posedge clk) disable iff (!arst_n)
		tone_valid && (tone.tone_freq == 16'd0) |-> tone.tone_amplitude == 16'd0)
		else $error("silent tone with nonzero amplitude");

	a_push_no_tone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd.kind != KIND_TICK) |=> !tone_valid)
		else $error("tone after a non-tick command");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

endmodule

bind tone_queue_sequencer tqs_checker u_tqs_checker (.*);
